// File: src/plane_coefficient_kalman_filter_macros.svh
// Assertion macros for the plane coefficient Kalman filter.
`ifndef PLANE_COEFFICIENT_KALMAN_FILTER_MACROS_SVH
`define PLANE_COEFFICIENT_KALMAN_FILTER_MACROS_SVH

`ifndef SYNTH
`define PCKF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
`define PCKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PCKF_ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define PCKF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// File: src/pckf_pkg.sv
// Shared types, constants and divider step for the plane coefficient Kalman filter.
`default_nettype none
package pckf_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned LANES         = 4;
  localparam int unsigned LANE_W        = 2;
  localparam int unsigned DIV_W         = 64;
  localparam int unsigned DIV_STEPS     = DIV_W / 2;
  localparam int unsigned CNT_W         = $clog2(DIV_STEPS);

  localparam logic [1:0] CMD_INIT    = 2'd0;
  localparam logic [1:0] CMD_PREDICT = 2'd1;
  localparam logic [1:0] CMD_UPDATE  = 2'd2;

  localparam logic [1:0] REG_INIT_VAR   = 2'd0;
  localparam logic [1:0] REG_PROC_NOISE = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd2;

  localparam logic [31:0] INIT_VAR_RST   = 32'd65536;
  localparam logic [31:0] PROC_NOISE_RST = 32'd66;
  localparam logic [31:0] MEAS_NOISE_RST = 32'd6554;

  typedef struct packed {
    logic              capture;
    logic              init;
    logic              predict;
    logic              start_lane;
    logic              div_step;
    logic              mul_gain;
    logic              write_lane;
    logic              load_out;
    logic [LANE_W-1:0] lane;
  } cmd_t;

  typedef struct packed {
    logic ready;
    logic s_zero;
  } sts_t;

  typedef struct packed {
    logic [32:0]      rem;
    logic [DIV_W-1:0] dvd;
  } div_t;

  function automatic div_t div_step(input logic [32:0] rem, input logic [DIV_W-1:0] dvd,
                                    input logic [32:0] den);
    logic [33:0] sh;
    logic [33:0] diff;
    div_t        res;
    sh   = {rem, dvd[DIV_W-1]};
    diff = sh - {1'b0, den};
    if (!diff[33]) begin
      res.rem = diff[32:0];
      res.dvd = {dvd[DIV_W-2:0], 1'b1};
    end else begin
      res.rem = sh[32:0];
      res.dvd = {dvd[DIV_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// File: src/plane_coefficient_kalman_filter.sv
// Plane coefficient Kalman filter: four scalar Q16.16 filters behind valid/ready channels.
//
// Input channel (in_valid_i/in_ready_o) carries one word: cmd_i and coef_0_i..coef_3_i.
// cmd 0 loads the estimates and sets every variance to the initial variance; cmd 1 adds
// the process variance to each variance (saturating); cmd 2 blends the measurement in.
// Predict and update do nothing until an init has been seen; cmd 3 does nothing.
// Output channel (out_valid_o/out_ready_i) returns one word per input word:
// is_ready_o and est_0_o..est_3_o after the command.
// Init, predict and no-op go straight to the done state, which loads the output word and raises
// out_valid_o once the output register is free. Update runs the lanes one after another through
// one multiplier and two dividers that retire two quotient bits per cycle (states S_LANE, S_DIV,
// S_MUL, S_WR; a lane with P + R zero is skipped); input waits until the result is loaded.
// The output word sits in a register: a new input word is taken while it waits,
// and a stalled receiver only holds the next finished word in its last step.
// Configuration (cfg_we_i, cfg_idx_i, cfg_wdata_i) writes the initial variance (0),
// process variance (1) or measurement variance (2); write only while idle.
// Reset clears the estimates, variances and init flag and restores register defaults.
`default_nettype none
module plane_coefficient_kalman_filter #(
  parameter int unsigned FRAC_BITS = pckf_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         cmd_i,
  input  wire logic signed [31:0] coef_0_i,
  input  wire logic signed [31:0] coef_1_i,
  input  wire logic signed [31:0] coef_2_i,
  input  wire logic signed [31:0] coef_3_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    is_ready_o,
  output logic signed [31:0]      est_0_o,
  output logic signed [31:0]      est_1_o,
  output logic signed [31:0]      est_2_o,
  output logic signed [31:0]      est_3_o
);
  import pckf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  pckf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pckf_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_0_i    (coef_0_i),
    .coef_1_i    (coef_1_i),
    .coef_2_i    (coef_2_i),
    .coef_3_i    (coef_3_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .is_ready_o  (is_ready_o),
    .est_0_o     (est_0_o),
    .est_1_o     (est_1_o),
    .est_2_o     (est_2_o),
    .est_3_o     (est_3_o)
  );

endmodule
`default_nettype wire

// File: src/pckf_dp.sv
// Datapath: lane state, config registers, shared multiplier and two-bit-per-cycle dividers.
`default_nettype none
module pckf_dp #(
  parameter int unsigned FRAC_BITS = pckf_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [1:0]         cfg_idx_i,
  input  wire logic [31:0]        cfg_wdata_i,
  input  wire logic signed [31:0] coef_0_i,
  input  wire logic signed [31:0] coef_1_i,
  input  wire logic signed [31:0] coef_2_i,
  input  wire logic signed [31:0] coef_3_i,
  input  wire pckf_pkg::cmd_t     cmd_i,
  output pckf_pkg::sts_t          sts_o,
  output logic                    is_ready_o,
  output logic signed [31:0]      est_0_o,
  output logic signed [31:0]      est_1_o,
  output logic signed [31:0]      est_2_o,
  output logic signed [31:0]      est_3_o
);
  import pckf_pkg::*;

  logic [31:0]      init_var_q, proc_noise_q, meas_noise_q;
  logic [31:0]      est_q [LANES];
  logic [31:0]      var_q [LANES];
  logic [31:0]      z_q   [LANES];
  logic [31:0]      out_est_q [LANES];
  logic             ready_q, out_ready_q;
  logic [32:0]      s_q;
  logic [32:0]      rem_a_q, rem_b_q;
  logic [DIV_W-1:0] dvd_a_q, dvd_b_q;
  logic [32:0]      mag_q;
  logic             neg_q;
  logic [65:0]      prod_q;

  logic [31:0]      sel_var, sel_est, sel_z;
  logic [32:0]      s_sum;
  logic [32:0]      diff, mag;
  logic [32:0]      gain_ext, mul_a, mul_b;
  logic [65:0]      mul_p;
  logic [65:0]      rnd;
  logic [33:0]      corr, x_ext, nx;
  logic [31:0]      pred_var [LANES];
  logic [32:0]      pred_sum [LANES];
  div_t             a1, a2, b1, b2;

  assign sel_var = var_q[cmd_i.lane];
  assign sel_est = est_q[cmd_i.lane];
  assign sel_z   = z_q[cmd_i.lane];
  assign s_sum   = {1'b0, sel_var} + {1'b0, meas_noise_q};

  assign sts_o.ready  = ready_q;
  assign sts_o.s_zero = (s_sum == 33'd0);

  assign diff = {sel_z[31], sel_z} - {sel_est[31], sel_est};
  assign mag  = diff[32] ? (33'd0 - diff) : diff;

  assign gain_ext = {{(32 - FRAC_BITS){1'b0}}, dvd_a_q[FRAC_BITS:0]};
  assign mul_a    = cmd_i.start_lane ? {1'b0, sel_var} : gain_ext;
  assign mul_b    = cmd_i.start_lane ? {1'b0, meas_noise_q} : mag_q;
  assign mul_p    = mul_a * mul_b;

  assign rnd   = prod_q + (66'd1 << (FRAC_BITS - 1));
  assign corr  = rnd[FRAC_BITS+33:FRAC_BITS];
  assign x_ext = {{2{sel_est[31]}}, sel_est};
  assign nx    = neg_q ? (x_ext - corr) : (x_ext + corr);

  assign a1 = div_step(rem_a_q, dvd_a_q, s_q);
  assign a2 = div_step(a1.rem, a1.dvd, s_q);
  assign b1 = div_step(rem_b_q, dvd_b_q, s_q);
  assign b2 = div_step(b1.rem, b1.dvd, s_q);

  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      pred_sum[k] = {1'b0, var_q[k]} + {1'b0, proc_noise_q};
      pred_var[k] = pred_sum[k][32] ? 32'hFFFF_FFFF : pred_sum[k][31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_var_q   <= INIT_VAR_RST;
      proc_noise_q <= PROC_NOISE_RST;
      meas_noise_q <= MEAS_NOISE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_INIT_VAR:   init_var_q   <= cfg_wdata_i;
        REG_PROC_NOISE: proc_noise_q <= cfg_wdata_i;
        REG_MEAS_NOISE: meas_noise_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q     <= 1'b0;
      out_ready_q <= 1'b0;
      for (int k = 0; k < LANES; k++) begin
        est_q[k]     <= '0;
        var_q[k]     <= '0;
        out_est_q[k] <= '0;
      end
    end else begin
      if (cmd_i.init) begin
        ready_q  <= 1'b1;
        est_q[0] <= coef_0_i;
        est_q[1] <= coef_1_i;
        est_q[2] <= coef_2_i;
        est_q[3] <= coef_3_i;
        for (int k = 0; k < LANES; k++) begin
          var_q[k] <= init_var_q;
        end
      end
      if (cmd_i.predict) begin
        for (int k = 0; k < LANES; k++) begin
          var_q[k] <= pred_var[k];
        end
      end
      if (cmd_i.write_lane) begin
        est_q[cmd_i.lane] <= nx[31:0];
        var_q[cmd_i.lane] <= dvd_b_q[31:0];
      end
      if (cmd_i.load_out) begin
        out_ready_q <= ready_q;
        for (int k = 0; k < LANES; k++) begin
          out_est_q[k] <= est_q[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      z_q[0] <= coef_0_i;
      z_q[1] <= coef_1_i;
      z_q[2] <= coef_2_i;
      z_q[3] <= coef_3_i;
    end
    if (cmd_i.start_lane) begin
      s_q     <= s_sum;
      rem_a_q <= '0;
      rem_b_q <= '0;
      dvd_a_q <= DIV_W'(sel_var) << FRAC_BITS;
      dvd_b_q <= mul_p[DIV_W-1:0];
      mag_q   <= mag;
      neg_q   <= diff[32];
    end
    if (cmd_i.div_step) begin
      rem_a_q <= a2.rem;
      dvd_a_q <= a2.dvd;
      rem_b_q <= b2.rem;
      dvd_b_q <= b2.dvd;
    end
    if (cmd_i.mul_gain) begin
      prod_q <= mul_p;
    end
  end

  assign is_ready_o = out_ready_q;
  assign est_0_o    = out_est_q[0];
  assign est_1_o    = out_est_q[1];
  assign est_2_o    = out_est_q[2];
  assign est_3_o    = out_est_q[3];

endmodule
`default_nettype wire

// File: src/pckf_ctrl.sv
// Controller: sequences init, predict and the per-lane update through the datapath.
`default_nettype none
`include "plane_coefficient_kalman_filter_macros.svh"
module pckf_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     cmd_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  input  wire pckf_pkg::sts_t sts_i,
  output pckf_pkg::cmd_t      cmd_o
);
  import pckf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LANE = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_WR   = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  localparam logic [CNT_W-1:0]  CNT_LAST  = CNT_W'(DIV_STEPS - 1);
  localparam logic [LANE_W-1:0] LANE_LAST = LANE_W'(LANES - 1);

  logic [2:0]        state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [LANE_W-1:0] lane_q, lane_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    lane_d      = lane_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.lane  = lane_q;
    cmd_o.capture = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DONE;
          lane_d  = '0;
          case (cmd_i)
            CMD_INIT:    cmd_o.init = 1'b1;
            CMD_PREDICT: cmd_o.predict = sts_i.ready;
            CMD_UPDATE: begin
              if (sts_i.ready) begin
                state_d = S_LANE;
              end
            end
            default: ;
          endcase
        end
      end
      S_LANE: begin
        if (sts_i.s_zero) begin
          if (lane_q == LANE_LAST) begin
            state_d = S_DONE;
          end else begin
            lane_d = lane_q + 1'b1;
          end
        end else begin
          cmd_o.start_lane = 1'b1;
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_gain = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        cmd_o.write_lane = 1'b1;
        if (lane_q == LANE_LAST) begin
          state_d = S_DONE;
        end else begin
          lane_d  = lane_q + 1'b1;
          state_d = S_LANE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      lane_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      lane_q      <= lane_d;
      out_valid_q <= out_valid_d;
    end
  end

  `PCKF_ASSERT_IMPLY(a_no_overwrite, clk_i, rst_ni, cmd_o.load_out, !out_valid_q || out_ready_i, "result overwritten while pending")
  `PCKF_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, accept, !in_ready_o, "new word taken while busy")
  `PCKF_ASSERT_NEXT(a_div_done, clk_i, rst_ni, state_q == S_DIV && cnt_q == CNT_LAST, state_q == S_MUL, "divider did not finish on time")
  `PCKF_ASSERT_IMPLY(a_one_op, clk_i, rst_ni, 1'b1, $onehot0({cmd_o.init, cmd_o.predict, cmd_o.start_lane, cmd_o.div_step, cmd_o.mul_gain, cmd_o.write_lane}), "datapath commands overlap")

endmodule
`default_nettype wire
